/* rtl/cfcd_pkg.sv */
// ----------------------------------------------------------------------------
// cfcd_pkg
// Shared widths, codes, controller states and control structs for the
// cheapest-free-core dispatch block.
// ----------------------------------------------------------------------------
package cfcd_pkg;

    localparam int OP_W     = 1;
    localparam int COST_W   = 20;
    localparam int TIME_W   = 32;
    localparam int FIN_W    = 33;
    localparam int CHARGE_W = 52;
    localparam int TOTAL_W  = 64;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_TASK = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        RSP_LOADED   = 2'd0,
        RSP_ASSIGNED = 2'd1,
        RSP_DROPPED  = 2'd2,
        RSP_REJECTED = 2'd3
    } rsp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_MULT,
        ST_EMIT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted beat
        logic scan;      // read the core at the scan index, advance
        logic multiply;  // form cost * duration
        logic emit;      // update state, load the result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_task;
        logic no_cores;
        logic scan_last;
    } dp_sts_t;

endpackage

/* rtl/cfcd_req_if.sv */
// ----------------------------------------------------------------------------
// cfcd_req_if
// Input channel: valid/ready handshake with the load or task payload.
// ----------------------------------------------------------------------------
interface cfcd_req_if;
    import cfcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [COST_W-1:0] core_cost;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] duration;

    modport source (
        output valid,
        output operation,
        output core_cost,
        output arrival_time,
        output duration,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  core_cost,
        input  arrival_time,
        input  duration,
        output ready
    );
endinterface

/* rtl/cfcd_rsp_if.sv */
// ----------------------------------------------------------------------------
// cfcd_rsp_if
// Output channel: valid/ready handshake with one result per item.
// ----------------------------------------------------------------------------
interface cfcd_rsp_if;
    import cfcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COST_W-1:0]   assigned_cost;
    logic [CHARGE_W-1:0] charge;
    logic [TOTAL_W-1:0]  total_cost;

    modport source (
        output valid,
        output status,
        output assigned_cost,
        output charge,
        output total_cost,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  assigned_cost,
        input  charge,
        input  total_cost,
        output ready
    );
endinterface

/* rtl/cfcd_ctrl.sv */
// ----------------------------------------------------------------------------
// cfcd_ctrl
// Sequencer: accept, dispatch, scan the core table, multiply, emit.
// Owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module cfcd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  cfcd_pkg::dp_sts_t sts,
    output cfcd_pkg::dp_cmd_t cmd
);
    import cfcd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        out_free;

    // result register can take a new beat
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (!sts.is_task || sts.no_cores)
                    state_next = ST_EMIT;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:    state_next = ST_MULT;
            ST_MULT:     state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_SCAN:     cmd.scan     = 1'b1;
            ST_MULT:     cmd.multiply = 1'b1;
            ST_EMIT:     cmd.emit     = out_free;
            default:     cmd          = '0;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/cfcd_dp.sv */
// ----------------------------------------------------------------------------
// cfcd_dp
// Core table (cost and finish-time memories, busy flags), scan compare
// stage, multiplier, running total and result register.
// ----------------------------------------------------------------------------
module cfcd_dp #(
    parameter int MAX_CORES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfcd_pkg::dp_cmd_t             cmd,
    output cfcd_pkg::dp_sts_t             sts,
    input  logic [cfcd_pkg::OP_W-1:0]     in_operation,
    input  logic [cfcd_pkg::COST_W-1:0]   in_core_cost,
    input  logic [cfcd_pkg::TIME_W-1:0]   in_arrival_time,
    input  logic [cfcd_pkg::TIME_W-1:0]   in_duration,
    output logic [cfcd_pkg::STATUS_W-1:0] out_status,
    output logic [cfcd_pkg::COST_W-1:0]   out_assigned_cost,
    output logic [cfcd_pkg::CHARGE_W-1:0] out_charge,
    output logic [cfcd_pkg::TOTAL_W-1:0]  out_total_cost
);
    import cfcd_pkg::*;

    localparam int IDX_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int CNT_W = $clog2(MAX_CORES + 1);

    // latched item
    logic [OP_W-1:0]     op_reg;
    logic [COST_W-1:0]   cost_in_reg;
    logic [TIME_W-1:0]   arrival_reg;
    logic [TIME_W-1:0]   dur_reg;

    // table state
    logic [COST_W-1:0]   cost_mem [MAX_CORES];
    logic [FIN_W-1:0]    fin_mem  [MAX_CORES];
    logic [MAX_CORES-1:0] busy_reg;
    logic [CNT_W-1:0]    loaded_count_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;

    // scan
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic                chk_vld_reg;
    logic [COST_W-1:0]   cost_rd_reg;
    logic [FIN_W-1:0]    fin_rd_reg;
    logic                release_hit;
    logic                core_free;
    logic                take_core;

    // selection
    logic                found_reg;
    logic [COST_W-1:0]   best_cost_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [CHARGE_W-1:0] charge_reg;

    logic                table_full;
    logic                is_task;
    logic                assign_now;
    logic [FIN_W-1:0]    finish_time;

    assign is_task     = (op_reg == OP_TASK);
    assign table_full  = (loaded_count_reg == CNT_W'(MAX_CORES));
    assign assign_now  = cmd.emit && is_task && found_reg;
    assign finish_time = FIN_W'(arrival_reg) + FIN_W'(dur_reg);

    assign sts.is_task   = is_task;
    assign sts.no_cores  = (loaded_count_reg == '0);
    assign sts.scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == loaded_count_reg);

    // compare stage on the registered table read
    assign release_hit = chk_vld_reg && busy_reg[chk_idx_reg]
                         && (fin_rd_reg <= FIN_W'(arrival_reg));
    assign core_free   = !busy_reg[chk_idx_reg] || release_hit;
    assign take_core   = chk_vld_reg && core_free
                         && (!found_reg || (cost_rd_reg < best_cost_reg));

    assign total_next = (assign_now) ? total_reg + TOTAL_W'(charge_reg) : total_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= in_operation;
            cost_in_reg <= in_core_cost;
            arrival_reg <= in_arrival_time;
            dur_reg     <= in_duration;
        end
    end

    // table memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.emit && !is_task && !table_full)
            cost_mem[loaded_count_reg[IDX_W-1:0]] <= cost_in_reg;
        cost_rd_reg <= cost_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (assign_now)
            fin_mem[best_idx_reg] <= finish_time;
        fin_rd_reg <= fin_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= '0;
            loaded_count_reg <= '0;
            total_reg        <= '0;
            scan_idx_reg     <= '0;
            chk_idx_reg      <= '0;
            chk_vld_reg      <= 1'b0;
            found_reg        <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= cmd.scan;
            chk_idx_reg <= scan_idx_reg;

            if (cmd.capture)
                scan_idx_reg <= '0;
            else if (cmd.scan)
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);

            // release is sticky even when the task ends up dropped
            if (release_hit)
                busy_reg[chk_idx_reg] <= 1'b0;
            if (assign_now)
                busy_reg[best_idx_reg] <= 1'b1;

            if (cmd.capture)
                found_reg <= 1'b0;
            else if (take_core)
                found_reg <= 1'b1;

            if (cmd.emit && !is_task && !table_full)
                loaded_count_reg <= loaded_count_reg + CNT_W'(1);

            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_core)
        begin
            best_cost_reg <= cost_rd_reg;
            best_idx_reg  <= chk_idx_reg;
        end
        if (cmd.multiply)
            charge_reg <= CHARGE_W'(best_cost_reg) * CHARGE_W'(dur_reg);
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_total_cost    <= total_next;
            out_assigned_cost <= '0;
            out_charge        <= '0;
            if (!is_task)
                out_status <= table_full ? RSP_REJECTED : RSP_LOADED;
            else if (found_reg)
            begin
                out_status        <= RSP_ASSIGNED;
                out_assigned_cost <= best_cost_reg;
                out_charge        <= charge_reg;
            end
            else
                out_status <= RSP_DROPPED;
        end
    end

endmodule

/* rtl/cheapest_free_core_dispatch_unit.sv */
// ----------------------------------------------------------------------------
// cheapest_free_core_dispatch_unit
// Core table with cheapest-free-core task dispatch and running cost total.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat content
//   -------  ---  ----------------------------------------------------------
//   req      in   operation, core_cost, arrival_time, duration
//   rsp      out  status, assigned_cost, charge, total_cost (one per req beat)
//
// Sequence: a load, or a task on an empty table, goes from accept through the
//   dispatch step straight to emit. Any other task also scans the table: the scan
//   reads one core per cycle from the cost and finish-time memories (one read
//   port each), then one compare stage, one multiply stage and the emit step.
// Reset: rst_n clears the busy flags, core count, running total and control;
//   the table memories are not cleared, only loaded entries are ever read.
// Stalls: req is taken whenever the sequencer is idle, even while a result
//   still sits in the output register; an item waits in its emit step only
//   until that register is drained by rsp.ready.
//
module cheapest_free_core_dispatch_unit #(
    parameter int MAX_CORES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    cfcd_req_if.sink   req,
    cfcd_rsp_if.source rsp
);
    import cfcd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: owns valid/ready of both channels
    cfcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table, selection, multiplier and result payload
    cfcd_dp #(
        .MAX_CORES (MAX_CORES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .in_operation      (req.operation),
        .in_core_cost      (req.core_cost),
        .in_arrival_time   (req.arrival_time),
        .in_duration       (req.duration),
        .out_status        (rsp.status),
        .out_assigned_cost (rsp.assigned_cost),
        .out_charge        (rsp.charge),
        .out_total_cost    (rsp.total_cost)
    );

endmodule
